@@ hw/rtl/avsync_pkg.sv @@
// ----------------------------------------------------------------------------
// avsync_pkg
// shared codes, widths and register reset values of the a/v sync clock block
// ----------------------------------------------------------------------------
package avsync_pkg;

  localparam int TIME_WIDTH_DEF = 48;

  // field widths
  localparam int CMD_W     = 2;
  localparam int NOW_W     = 47;
  localparam int PTS_W     = 48;
  localparam int SERIAL_W  = 15;
  localparam int TAG_W     = 16;
  localparam int DELAY_W   = 27;
  localparam int TARGET_W  = 28;
  localparam int THR_W     = 20;
  localparam int LIMIT_W   = 27;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 3;

  // event codes
  localparam logic [CMD_W-1:0] CMD_VIDEO = 2'd0;
  localparam logic [CMD_W-1:0] CMD_AUDIO = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMEDUP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]   SYNC_MIN_RST  = 20'd40000;
  localparam logic [THR_W-1:0]   SYNC_MAX_RST  = 20'd100000;
  localparam logic [THR_W-1:0]   FRAMEDUP_RST  = 20'd100000;
  localparam logic [LIMIT_W-1:0] NOSYNC_RST    = 27'd10000000;
  localparam logic [LIMIT_W-1:0] MAX_FRAME_RST = 27'd10000000;

  localparam logic [TAG_W-1:0] TAG_NONE = 16'hFFFF;

endpackage

@@ hw/rtl/av_sync_clock_delay.sv @@
// ----------------------------------------------------------------------------
// av_sync_clock_delay
// video, audio and external presentation clocks with frame delay correction
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | cmd, times, pts, serials, delay
//  out_     | output    | out_valid/out_stall| target delay and status flags
//  cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// one beat per cycle sustained unless out_stall holds the result register;
// a beat passes the input register, then the clock update and result register
// in one pass of saturating add logic; synchronous reset, no clearing pass
// in_stall rises only while the input register is full and the result
// register is held by out_stall; a beat waiting at the output does not block
// the next input beat
// ----------------------------------------------------------------------------
module av_sync_clock_delay
  import avsync_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic [NOW_W-1:0]           in_now_us,
  input  logic [NOW_W-1:0]           in_stamp_us,
  input  logic signed [PTS_W-1:0]    in_pts_us,
  input  logic                       in_pts_valid,
  input  logic [SERIAL_W-1:0]        in_clock_serial,
  input  logic [SERIAL_W-1:0]        in_video_queue_serial,
  input  logic [SERIAL_W-1:0]        in_audio_queue_serial,
  input  logic [DELAY_W-1:0]         in_delay_us,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [TARGET_W-1:0]        out_target_delay_us,
  output logic                       out_ext_resynced,
  output logic                       out_diff_valid,
  output logic                       out_paused_now,

  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int TW = TIME_WIDTH;
  localparam int XW = 65;

  typedef logic signed [TW-1:0] time_t;

  localparam time_t TMAX = {1'b0, {(TW-1){1'b1}}};
  localparam time_t TMIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [XW-1:0] XMAX = {{(XW-TW){1'b0}}, TMAX};
  localparam logic signed [XW-1:0] XMIN = {{(XW-TW){1'b1}}, TMIN};

  function automatic time_t clamp_x(input logic signed [XW-1:0] v);
    time_t r;
    if (v > XMAX) begin
      r = TMAX;
    end else if (v < XMIN) begin
      r = TMIN;
    end else begin
      r = v[TW-1:0];
    end
    return r;
  endfunction

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic signed [TW:0] s;
    time_t r;
    s = {a[TW-1], a} + {b[TW-1], b};
    if (s[TW] != s[TW-1]) begin
      r = s[TW] ? TMIN : TMAX;
    end else begin
      r = s[TW-1:0];
    end
    return r;
  endfunction

  function automatic time_t sat_sub(input time_t a, input time_t b);
    logic signed [TW:0] s;
    time_t r;
    s = {a[TW-1], a} - {b[TW-1], b};
    if (s[TW] != s[TW-1]) begin
      r = s[TW] ? TMIN : TMAX;
    end else begin
      r = s[TW-1:0];
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] mag(input time_t v);
    logic [TW-1:0] r;
    r = v[TW-1] ? (~v + {{(TW-1){1'b0}}, 1'b1}) : v;
    return r;
  endfunction

  // configuration
  logic [THR_W-1:0]   sync_min_r, sync_max_r, framedup_r;
  logic [LIMIT_W-1:0] nosync_r, max_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r  <= SYNC_MIN_RST;
      sync_max_r  <= SYNC_MAX_RST;
      framedup_r  <= FRAMEDUP_RST;
      nosync_r    <= NOSYNC_RST;
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_MIN:  sync_min_r  <= cfg_wdata[THR_W-1:0];
        REG_SYNC_MAX:  sync_max_r  <= cfg_wdata[THR_W-1:0];
        REG_FRAMEDUP:  framedup_r  <= cfg_wdata[THR_W-1:0];
        REG_NOSYNC:    nosync_r    <= cfg_wdata[LIMIT_W-1:0];
        REG_MAX_FRAME: max_frame_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                    s1_valid_r;
  logic [CMD_W-1:0]        s1_cmd_r;
  logic [NOW_W-1:0]        s1_now_r, s1_stamp_r;
  logic signed [PTS_W-1:0] s1_pts_r;
  logic                    s1_pts_ok_r;
  logic [SERIAL_W-1:0]     s1_serial_r, s1_vq_r, s1_aq_r;
  logic [DELAY_W-1:0]      s1_delay_r;

  logic out_valid_r;
  logic adv;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r    <= in_cmd;
      s1_now_r    <= in_now_us;
      s1_stamp_r  <= in_stamp_us;
      s1_pts_r    <= in_pts_us;
      s1_pts_ok_r <= in_pts_valid;
      s1_serial_r <= in_clock_serial;
      s1_vq_r     <= in_video_queue_serial;
      s1_aq_r     <= in_audio_queue_serial;
      s1_delay_r  <= in_delay_us;
    end
  end

  // clock state; the video, audio and external clocks share the pause flag paused_r
  time_t            vid_pts_r, vid_drift_r, aud_pts_r, aud_drift_r, ext_pts_r, ext_drift_r;
  logic [TAG_W-1:0] vid_tag_r, aud_tag_r;
  logic             vid_valid_r, aud_valid_r, ext_valid_r, paused_r;

  time_t            vid_pts_nxt, vid_drift_nxt, aud_pts_nxt, aud_drift_nxt;
  time_t            ext_pts_nxt, ext_drift_nxt;
  logic [TAG_W-1:0] vid_tag_nxt, aud_tag_nxt;
  logic             vid_valid_nxt, aud_valid_nxt, ext_valid_nxt, paused_nxt;

  time_t now_t, stamp_t, pts_t, t_set, sl_drift, sl_val, sl_rebase;
  time_t ext_val, ext_rebase, vid_run, vid_val, vid_rebase, diff;
  logic [SERIAL_W-1:0] q_sel;
  logic  is_aud, sl_ok, do_resync, vid_ok, corr_ok, neg_hit, pos_hit;
  logic [THR_W-1:0] thr_hi, thr;
  logic signed [28:0] diff_n, thr_n, sum_n;
  logic [TARGET_W-1:0] target;
  logic resynced, diff_ok;

  always_comb begin
    now_t   = clamp_x({{(XW-NOW_W){1'b0}}, s1_now_r});
    stamp_t = clamp_x({{(XW-NOW_W){1'b0}}, s1_stamp_r});
    pts_t   = clamp_x({{(XW-PTS_W){s1_pts_r[PTS_W-1]}}, s1_pts_r});

    // slave clock set and resync of the external clock
    is_aud    = s1_cmd_r == CMD_AUDIO;
    t_set     = is_aud ? stamp_t : now_t;
    sl_drift  = sat_sub(pts_t, t_set);
    sl_val    = paused_r ? pts_t : sat_add(sl_drift, now_t);
    q_sel     = is_aud ? s1_aq_r : s1_vq_r;
    sl_ok     = s1_pts_ok_r && (s1_serial_r == q_sel);
    ext_val   = paused_r ? ext_pts_r : sat_add(ext_drift_r, now_t);
    do_resync = sl_ok && (!ext_valid_r ||
                (mag(sat_sub(ext_val, sl_val)) > {{(TW-LIMIT_W){1'b0}}, nosync_r}));
    sl_rebase = sat_sub(sl_val, now_t);
    ext_rebase = sat_sub(ext_val, now_t);

    // video read
    vid_ok     = vid_valid_r && (vid_tag_r == {1'b0, s1_vq_r});
    vid_run    = sat_add(vid_drift_r, now_t);
    vid_val    = paused_r ? vid_pts_r : vid_run;
    vid_rebase = sat_sub(vid_run, now_t);
    diff       = sat_sub(vid_val, ext_val);

    // delay correction
    thr_hi  = ({{(DELAY_W-THR_W){1'b0}}, sync_max_r} > s1_delay_r) ?
              s1_delay_r[THR_W-1:0] : sync_max_r;
    thr     = (thr_hi < sync_min_r) ? sync_min_r : thr_hi;
    corr_ok = vid_ok && ext_valid_r &&
              (mag(diff) < {{(TW-LIMIT_W){1'b0}}, max_frame_r});
    diff_n  = diff[28:0];
    thr_n   = {9'b0, thr};
    neg_hit = diff_n <= -thr_n;
    pos_hit = diff_n >= thr_n;
    sum_n   = {2'b0, s1_delay_r} + diff_n;
    target  = {1'b0, s1_delay_r};
    if (corr_ok) begin
      priority if (neg_hit) begin
        target = sum_n[28] ? '0 : sum_n[TARGET_W-1:0];
      end else if (pos_hit && (s1_delay_r > {{(DELAY_W-THR_W){1'b0}}, framedup_r})) begin
        target = sum_n[TARGET_W-1:0];
      end else if (pos_hit) begin
        target = {s1_delay_r, 1'b0};
      end else begin
        target = {1'b0, s1_delay_r};
      end
    end

    vid_pts_nxt   = vid_pts_r;
    vid_drift_nxt = vid_drift_r;
    vid_tag_nxt   = vid_tag_r;
    vid_valid_nxt = vid_valid_r;
    aud_pts_nxt   = aud_pts_r;
    aud_drift_nxt = aud_drift_r;
    aud_tag_nxt   = aud_tag_r;
    aud_valid_nxt = aud_valid_r;
    ext_pts_nxt   = ext_pts_r;
    ext_drift_nxt = ext_drift_r;
    ext_valid_nxt = ext_valid_r;
    paused_nxt    = paused_r;
    resynced      = 1'b0;

    unique case (s1_cmd_r)
      CMD_VIDEO, CMD_AUDIO: begin
        if (is_aud) begin
          aud_tag_nxt   = {1'b0, s1_serial_r};
          aud_valid_nxt = s1_pts_ok_r;
          aud_pts_nxt   = s1_pts_ok_r ? pts_t : '0;
          aud_drift_nxt = s1_pts_ok_r ? sl_drift : '0;
        end else begin
          vid_tag_nxt   = {1'b0, s1_serial_r};
          vid_valid_nxt = s1_pts_ok_r;
          vid_pts_nxt   = s1_pts_ok_r ? pts_t : '0;
          vid_drift_nxt = s1_pts_ok_r ? sl_drift : '0;
        end
        resynced = do_resync;
        if (do_resync) begin
          ext_valid_nxt = 1'b1;
          ext_pts_nxt   = sl_val;
          ext_drift_nxt = sl_rebase;
        end
      end
      CMD_QUERY: ;
      CMD_PAUSE: begin
        // on resume the video clock is rebased as a running clock
        if (paused_r) begin
          vid_valid_nxt = vid_ok;
          vid_pts_nxt   = vid_ok ? vid_run : '0;
          vid_drift_nxt = vid_ok ? vid_rebase : '0;
        end
        ext_pts_nxt   = ext_valid_r ? ext_val : '0;
        ext_drift_nxt = ext_valid_r ? ext_rebase : '0;
        paused_nxt    = !paused_r;
      end
      default: ;
    endcase

    diff_ok = vid_valid_nxt && (vid_tag_nxt == {1'b0, s1_vq_r}) && ext_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vid_valid_r <= 1'b0;
      aud_valid_r <= 1'b0;
      ext_valid_r <= 1'b0;
      paused_r    <= 1'b0;
      vid_tag_r   <= TAG_NONE;
      aud_tag_r   <= TAG_NONE;
    end else if (adv) begin
      vid_valid_r <= vid_valid_nxt;
      aud_valid_r <= aud_valid_nxt;
      ext_valid_r <= ext_valid_nxt;
      paused_r    <= paused_nxt;
      vid_tag_r   <= vid_tag_nxt;
      aud_tag_r   <= aud_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vid_pts_r   <= vid_pts_nxt;
      vid_drift_r <= vid_drift_nxt;
      aud_pts_r   <= aud_pts_nxt;
      aud_drift_r <= aud_drift_nxt;
      ext_pts_r   <= ext_pts_nxt;
      ext_drift_r <= ext_drift_nxt;
    end
  end

  // result register
  logic [TARGET_W-1:0] out_target_r;
  logic                out_resync_r, out_diff_ok_r, out_paused_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_target_r  <= (s1_cmd_r == CMD_QUERY) ? target : '0;
      out_resync_r  <= resynced;
      out_diff_ok_r <= diff_ok;
      out_paused_r  <= paused_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target_delay_us = out_target_r;
  assign out_ext_resynced    = out_resync_r;
  assign out_diff_valid      = out_diff_ok_r;
  assign out_paused_now      = out_paused_r;

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_state_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(paused_r) && $stable(ext_valid_r) && $stable(vid_valid_r)))
    else $error("clock state changed without a beat");

  a_paused_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_paused_r == paused_r))
    else $error("reported pause state differs from clock state");

  a_resync_sets_ext: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_resync_r || out_diff_ok_r)) |-> ext_valid_r)
    else $error("external clock invalid after resync or valid difference");

endmodule
